@@ hdl/c16lic_pkg.sv @@
// ----------------------------------------------------------------------------
// CRC-16 line checker package
// Shared types, byte codes, status codes and the byte-wide CRC and hex
// helpers used by the line checker.
// ----------------------------------------------------------------------------
package c16lic_pkg;

   typedef logic [7:0]  byte_type;
   typedef logic [15:0] crc_type;
   typedef logic [1:0]  status_type;

   typedef struct packed {
      logic       valid;
      logic [3:0] value;
   } hex_digit_type;

   localparam byte_type StarByte    = 8'h2A;
   localparam byte_type NewlineByte = 8'h0A;
   localparam byte_type ZeroByte    = 8'h00;

   localparam crc_type CrcPoly = 16'h1021;

   localparam status_type StatusOk        = 2'd0;
   localparam status_type StatusIntegrity = 2'd1;
   localparam status_type StatusTooLong   = 2'd2;

   // One CRC-16/XMODEM update by a whole byte, most significant bit first.
   function automatic crc_type crc_update(input crc_type crc, input byte_type data);
      crc_type c;
      c = crc ^ {data, 8'h00};
      for (int i = 0; i < 8; i++) begin
         if (c[15]) begin
            c = {c[14:0], 1'b0} ^ CrcPoly;
         end else begin
            c = {c[14:0], 1'b0};
         end
      end
      return c;
   endfunction

   // Decodes an ASCII hex digit of either case.
   function automatic hex_digit_type hex_decode(input byte_type data);
      hex_digit_type d;
      d.valid = 1'b0;
      d.value = 4'h0;
      if (data >= 8'h30 && data <= 8'h39) begin
         d.valid = 1'b1;
         d.value = data[3:0];
      end else if ((data >= 8'h41 && data <= 8'h46) || (data >= 8'h61 && data <= 8'h66)) begin
         d.valid = 1'b1;
         d.value = data[3:0] + 4'd9;
      end
      return d;
   endfunction

endpackage

@@ hdl/c16lic_req_if.sv @@
// ----------------------------------------------------------------------------
// CRC-16 line checker byte channel
// Valid/ready channel carrying one received byte per item.
// ----------------------------------------------------------------------------
interface c16lic_req_if import c16lic_pkg::*; ();

   logic     valid;
   logic     ready;
   byte_type data_byte;

   modport source (output valid, output data_byte, input ready);
   modport sink   (input valid, input data_byte, output ready);

endinterface

@@ hdl/c16lic_rsp_if.sv @@
// ----------------------------------------------------------------------------
// CRC-16 line checker result channel
// Valid/ready channel carrying one line status per item.
// ----------------------------------------------------------------------------
interface c16lic_rsp_if import c16lic_pkg::*; ();

   logic       valid;
   logic       ready;
   status_type status;
   logic [7:0] content_length;

   modport source (output valid, output status, output content_length, input ready);
   modport sink   (input valid, input status, input content_length, output ready);

endinterface

@@ hdl/crc16_line_integrity_checker_unit.sv @@
// ----------------------------------------------------------------------------
// CRC-16 line integrity checker
// Checks text lines of the form content*HEX against a CRC-16/XMODEM.
//
// Usage: received bytes enter on req_chan, one byte per item. Zero bytes
// are accepted and dropped. Each newline byte gives one item on rsp_chan
// with the line status (ok, integrity error, line too long) and the number
// of content bytes before the asterisk.
// Throughput is one byte per cycle: the byte-wide CRC update and the hex
// digit shift sit between the input register and the state and result
// registers. An accepted newline reaches the result register from the input
// register. The result register parts the two channels, so bytes that give
// no result keep flowing while a result waits; a newline waits in the input
// register only while an earlier result is still held.
// A line holds at most MAX_LINE - 1 bytes, newline included; longer lines
// are discarded up to their newline and reported as too long.
// Reset is synchronous and clears the line state and both valid flags.
// ----------------------------------------------------------------------------
module crc16_line_integrity_checker_unit import c16lic_pkg::*; #(
   parameter int MAX_LINE = 256
) (
   input logic           clock,
   input logic           reset,
   c16lic_req_if.sink    req_chan,
   c16lic_rsp_if.source  rsp_chan
);

   localparam int CountWidth = $clog2(MAX_LINE);
   localparam logic [CountWidth-1:0] LineLimit = CountWidth'(MAX_LINE - 1);

   logic       in_valid_ff;
   byte_type   in_byte_ff;

   crc_type                running_crc_ff, running_crc_in;
   crc_type                received_check_ff, received_check_in;
   logic                   star_seen_ff, star_seen_in;
   logic                   hex_active_ff, hex_active_in;
   logic [CountWidth-1:0]  byte_count_ff, byte_count_in;
   logic [CountWidth-1:0]  content_count_ff, content_count_in;
   logic                   overflowed_ff, overflowed_in;

   logic       out_valid_ff;
   status_type out_status_ff, out_status_in;
   logic [7:0] out_length_ff, out_length_in;

   logic          is_newline;
   logic          advance;
   logic          line_full;
   hex_digit_type digit;

   assign is_newline = (in_byte_ff == NewlineByte);
   assign advance    = in_valid_ff && (!is_newline || !out_valid_ff || rsp_chan.ready);
   assign req_chan.ready = !in_valid_ff || advance;

   assign line_full = overflowed_ff || (byte_count_ff == LineLimit);
   assign digit     = hex_decode(in_byte_ff);

   always_comb begin
      running_crc_in    = running_crc_ff;
      received_check_in = received_check_ff;
      star_seen_in      = star_seen_ff;
      hex_active_in     = hex_active_ff;
      byte_count_in     = byte_count_ff;
      content_count_in  = content_count_ff;
      overflowed_in     = overflowed_ff;
      out_status_in     = StatusOk;
      out_length_in     = 8'd0;
      if (is_newline) begin
         running_crc_in    = '0;
         received_check_in = '0;
         star_seen_in      = 1'b0;
         hex_active_in     = 1'b0;
         byte_count_in     = '0;
         content_count_in  = '0;
         overflowed_in     = 1'b0;
         if (line_full) begin
            out_status_in = StatusTooLong;
         end else if (!star_seen_ff) begin
            out_status_in = StatusIntegrity;
         end else begin
            out_status_in = (received_check_ff == running_crc_ff) ? StatusOk : StatusIntegrity;
            out_length_in = 8'(content_count_ff);
         end
      end else if (line_full) begin
         overflowed_in = 1'b1;
      end else begin
         byte_count_in = byte_count_ff + 1'b1;
         if (!star_seen_ff) begin
            if (in_byte_ff == StarByte) begin
               star_seen_in  = 1'b1;
               hex_active_in = 1'b1;
            end else begin
               running_crc_in   = crc_update(running_crc_ff, in_byte_ff);
               content_count_in = content_count_ff + 1'b1;
            end
         end else if (hex_active_ff) begin
            if (digit.valid) begin
               received_check_in = {received_check_ff[11:0], digit.value};
            end else begin
               hex_active_in = 1'b0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_chan.ready) begin
         in_valid_ff <= req_chan.valid && (req_chan.data_byte != ZeroByte);
      end
   end

   always_ff @(posedge clock) begin
      if (req_chan.ready) begin
         in_byte_ff <= req_chan.data_byte;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         running_crc_ff    <= '0;
         received_check_ff <= '0;
         star_seen_ff      <= 1'b0;
         hex_active_ff     <= 1'b0;
         byte_count_ff     <= '0;
         content_count_ff  <= '0;
         overflowed_ff     <= 1'b0;
      end else if (advance) begin
         running_crc_ff    <= running_crc_in;
         received_check_ff <= received_check_in;
         star_seen_ff      <= star_seen_in;
         hex_active_ff     <= hex_active_in;
         byte_count_ff     <= byte_count_in;
         content_count_ff  <= content_count_in;
         overflowed_ff     <= overflowed_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance && is_newline) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_chan.ready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && is_newline) begin
         out_status_ff <= out_status_in;
         out_length_ff <= out_length_in;
      end
   end

   assign rsp_chan.valid          = out_valid_ff;
   assign rsp_chan.status         = out_status_ff;
   assign rsp_chan.content_length = out_length_ff;

`ifndef SYNTH
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      byte_count_ff <= LineLimit && content_count_ff <= byte_count_ff)
      else $error("Line byte count out of range.");

   a_no_hex_before_star: assert property (@(posedge clock) disable iff (reset)
      !star_seen_ff |-> (!hex_active_ff && received_check_ff == 16'h0000))
      else $error("Hex field active before the asterisk.");

   a_newline_clears: assert property (@(posedge clock) disable iff (reset)
      (advance && is_newline) |=> (byte_count_ff == '0 && !overflowed_ff && out_valid_ff))
      else $error("Newline did not close the line.");

   a_no_lost_result: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && !rsp_chan.ready) |-> !(advance && is_newline))
      else $error("Result overwritten while held.");
`endif

endmodule

@@ sim/tb_top.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// CRC-16 line integrity checker testbench
// Feeds byte streams into the line checker and checks every line report
// against an in-bench line tracker or a typed table row. Hand-picked bytes from
// a short table come first, then lines of lengths near the line limit, then
// random framed, corrupted, unframed and noisy lines. Both channels idle at random.
// ----------------------------------------------------------------------------
module tb_top import c16lic_pkg::*; ();

   localparam int LineLimit     = 256;
   localparam int TimeoutCycles = 400000;
   localparam int DirectedCount = 23;

   typedef struct packed {
      status_type status;
      logic [7:0] content_length;
   } line_report_type;

   typedef struct packed {
      byte_type   data;
      logic       typed;
      status_type status;
      logic [7:0] length;
   } directed_row_type;

   typedef struct packed {
      crc_type    crc;
      crc_type    rx_check;
      logic       star;
      logic       hex_on;
      logic [7:0] stored;
      logic [7:0] content;
      logic       overflow;
   } line_state_type;

   localparam directed_row_type DirectedRows [DirectedCount] = '{
      '{NewlineByte, 1'b1, StatusIntegrity, 8'd0},
      '{ZeroByte,    1'b0, StatusOk,        8'd0},
      '{StarByte,    1'b0, StatusOk,        8'd0},
      '{NewlineByte, 1'b1, StatusOk,        8'd0},
      '{StarByte,    1'b0, StatusOk,        8'd0},
      '{8'h20,       1'b0, StatusOk,        8'd0},
      '{8'h31,       1'b0, StatusOk,        8'd0},
      '{NewlineByte, 1'b1, StatusOk,        8'd0},
      '{StarByte,    1'b0, StatusOk,        8'd0},
      '{8'h30,       1'b0, StatusOk,        8'd0},
      '{8'h78,       1'b0, StatusOk,        8'd0},
      '{NewlineByte, 1'b1, StatusOk,        8'd0},
      '{8'h41,       1'b0, StatusOk,        8'd0},
      '{StarByte,    1'b0, StatusOk,        8'd0},
      '{NewlineByte, 1'b1, StatusIntegrity, 8'd1},
      '{8'hFF,       1'b0, StatusOk,        8'd0},
      '{ZeroByte,    1'b0, StatusOk,        8'd0},
      '{8'h7F,       1'b0, StatusOk,        8'd0},
      '{StarByte,    1'b0, StatusOk,        8'd0},
      '{8'h66,       1'b0, StatusOk,        8'd0},
      '{8'h46,       1'b0, StatusOk,        8'd0},
      '{StarByte,    1'b0, StatusOk,        8'd0},
      '{NewlineByte, 1'b0, StatusOk,        8'd0}
   };

   logic clock;
   logic reset;

   c16lic_req_if req_bus ();
   c16lic_rsp_if rsp_bus ();

   crc16_line_integrity_checker_unit #(
      .MAX_LINE (LineLimit)
   ) DUT (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_bus),
      .rsp_chan (rsp_bus)
   );

   line_report_type awaited_reports [$];
   byte_type        line_bytes [$];
   line_state_type  tracked;
   int              failures = 0;
   int              cycles = 0;
   int              bytes_sent;
   int              lines_sent;
   int              stall_left = 0;
   bit              source_idles;
   bit              sink_idles = 1'b1;

   always begin
      #4 clock = 1'b0;
      #4 clock = 1'b1;
   end

   // Byte-wide CRC-16/XMODEM, one message bit at a time.
   function automatic crc_type crc_add_byte(input crc_type crc, input byte_type b);
      crc_type c;
      logic    fb;
      c = crc;
      for (int i = 7; i >= 0; i--) begin
         fb = c[15] ^ b[i];
         c  = {c[14:0], 1'b0} ^ (fb ? 16'h1021 : 16'h0000);
      end
      return c;
   endfunction

   function automatic int digit_of(input byte_type b);
      if (b >= 8'h30 && b <= 8'h39) return int'(b) - 8'h30;
      if (b >= 8'h41 && b <= 8'h46) return int'(b) - 8'h41 + 10;
      if (b >= 8'h61 && b <= 8'h66) return int'(b) - 8'h61 + 10;
      return -1;
   endfunction

   // Follows the line state for one accepted byte and yields the line report
   // that a newline brings.
   task automatic track_line_byte(input byte_type b, output bit got,
                                  output line_report_type rep);
      int d;
      got = 1'b0;
      rep = '0;
      if (b == ZeroByte) return;
      if (!tracked.overflow && tracked.stored >= LineLimit - 1) tracked.overflow = 1'b1;
      if (tracked.overflow) begin
         if (b == NewlineByte) begin
            got = 1'b1;
            rep.status = StatusTooLong;
            tracked = '0;
         end
         return;
      end
      tracked.stored = tracked.stored + 8'd1;
      if (b == NewlineByte) begin
         got = 1'b1;
         if (!tracked.star) begin
            rep.status = StatusIntegrity;
         end else begin
            rep.status = (tracked.rx_check == tracked.crc) ? StatusOk : StatusIntegrity;
            rep.content_length = tracked.content;
         end
         tracked = '0;
         return;
      end
      if (!tracked.star) begin
         if (b == StarByte) begin
            tracked.star   = 1'b1;
            tracked.hex_on = 1'b1;
         end else begin
            tracked.crc     = crc_add_byte(tracked.crc, b);
            tracked.content = tracked.content + 8'd1;
         end
      end else if (tracked.hex_on) begin
         d = digit_of(b);
         if (d < 0) begin
            tracked.hex_on = 1'b0;
         end else begin
            tracked.rx_check = {tracked.rx_check[11:0], 4'(d)};
         end
      end
   endtask

   task automatic feed_byte(input byte_type b, input bit typed,
                            input line_report_type typed_rep);
      int              gap;
      bit              got;
      line_report_type rep;
      gap = source_idles ? $urandom_range(0, 6) : 0;
      if (gap > 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_bus.valid     <= 1'b1;
      req_bus.data_byte <= b;
      do @(posedge clock); while (!req_bus.ready);
      track_line_byte(b, got, rep);
      if (got) awaited_reports.push_back(typed ? typed_rep : rep);
      if (b != ZeroByte) bytes_sent++;
   endtask

   task automatic drain_reports();
      req_bus.valid <= 1'b0;
      @(posedge clock);
      while (awaited_reports.size() != 0) @(posedge clock);
   endtask

   function automatic byte_type hex_char(input logic [3:0] nib);
      byte_type base;
      base = ($urandom_range(0, 1) != 0) ? 8'h41 : 8'h61;
      if (nib < 4'd10) return 8'h30 + byte_type'(nib);
      return base + byte_type'(nib) - 8'd10;
   endfunction

   function automatic byte_type pick_content_byte();
      byte_type b;
      do b = byte_type'($urandom_range(1, 255));
      while (b == NewlineByte || b == StarByte);
      return b;
   endfunction

   function automatic byte_type pick_any_byte();
      byte_type b;
      do b = byte_type'($urandom_range(1, 255));
      while (b == NewlineByte);
      return b;
   endfunction

   function automatic byte_type pick_non_hex();
      byte_type b;
      do b = pick_any_byte();
      while (digit_of(b) >= 0);
      return b;
   endfunction

   // Builds content*HEX with the check value of the content, optionally
   // corrupted. An exact line has no dropped bytes, no extra digits and no
   // trailing text, so that its stored length is known.
   task automatic compose_framed(input int n, input bit corrupt, input bit exact,
                                 input int digits);
      crc_type  c;
      byte_type b;
      c = '0;
      repeat (n) begin
         b = pick_content_byte();
         line_bytes.push_back(b);
         c = crc_add_byte(c, b);
         if (!exact && $urandom_range(0, 15) == 0) line_bytes.push_back(ZeroByte);
      end
      if (corrupt) c = c ^ (16'h0001 << $urandom_range(0, 15));
      line_bytes.push_back(StarByte);
      if (!exact) begin
         repeat ($urandom_range(0, 2)) line_bytes.push_back(hex_char(4'($urandom_range(0, 15))));
      end
      for (int i = digits - 1; i >= 0; i--) line_bytes.push_back(hex_char(c[i*4 +: 4]));
      if (!exact && $urandom_range(0, 2) == 0) begin
         line_bytes.push_back(pick_non_hex());
         repeat ($urandom_range(0, 3)) line_bytes.push_back(pick_any_byte());
      end
   endtask

   task automatic send_line();
      foreach (line_bytes[i]) feed_byte(line_bytes[i], 1'b0, '0);
      feed_byte(NewlineByte, 1'b0, '0);
      line_bytes.delete();
      lines_sent++;
   endtask

   task automatic compose_random_line();
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 55) begin
         compose_framed($urandom_range(0, 12), 1'b0, 1'b0, 4);
      end else if (pick < 70) begin
         compose_framed($urandom_range(0, 12), 1'b1, 1'b0, 4);
      end else if (pick < 78) begin
         compose_framed($urandom_range(0, 12), 1'b0, 1'b0, $urandom_range(0, 3));
      end else if (pick < 86) begin
         repeat ($urandom_range(0, 12)) line_bytes.push_back(pick_content_byte());
      end else if (pick < 98) begin
         repeat ($urandom_range(0, 14)) begin
            case ($urandom_range(0, 3))
               0: line_bytes.push_back(StarByte);
               1: line_bytes.push_back(hex_char(4'($urandom_range(0, 15))));
               2: line_bytes.push_back(ZeroByte);
               default: line_bytes.push_back(pick_any_byte());
            endcase
         end
      end else begin
         repeat ($urandom_range(240, 300)) line_bytes.push_back(pick_any_byte());
      end
   endtask

   initial begin
      reset             = 1'b1;
      req_bus.valid     = 1'b0;
      req_bus.data_byte = ZeroByte;
      tracked           = '0;
      bytes_sent        = 0;
      lines_sent        = 0;
      source_idles      = 1'b1;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      for (int i = 0; i < DirectedCount; i++) begin
         feed_byte(DirectedRows[i].data, DirectedRows[i].typed,
                   '{DirectedRows[i].status, DirectedRows[i].length});
      end
      drain_reports();

      // Lines around the length limit: one that just fits, one whose newline
      // overflows, one with the longest content and one far too long.
      compose_framed(249, 1'b0, 1'b1, 4);
      send_line();
      compose_framed(250, 1'b0, 1'b1, 4);
      send_line();
      compose_framed(253, 1'b0, 1'b1, 0);
      send_line();
      repeat (254) line_bytes.push_back(pick_content_byte());
      send_line();
      repeat (300) line_bytes.push_back(pick_any_byte());
      send_line();
      drain_reports();

      bytes_sent = 0;
      lines_sent = 0;
      while (bytes_sent < 500 || lines_sent < 48) begin
         if ($urandom_range(0, 5) == 0) source_idles = !source_idles;
         compose_random_line();
         send_line();
         if ($urandom_range(0, 9) == 0) drain_reports();
      end
      drain_reports();
      repeat (10) @(posedge clock);
      if (failures == 0) begin
         $display("tb_top: PASS");
      end else begin
         $display("tb_top: FAIL");
      end
      $finish;
   end

   always @(posedge clock) begin : result_sink
      line_report_type want;
      int              nxt;
      nxt = stall_left;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (awaited_reports.size() == 0) begin
            $error("unexpected line report: status %0d, content_length %0d",
                   rsp_bus.status, rsp_bus.content_length);
            failures++;
         end else begin
            want = awaited_reports.pop_front();
            if (rsp_bus.status !== want.status) begin
               $error("status mismatch: expected %0d, actual %0d",
                      want.status, rsp_bus.status);
               failures++;
            end
            if (rsp_bus.content_length !== want.content_length) begin
               $error("content_length mismatch: expected %0d, actual %0d",
                      want.content_length, rsp_bus.content_length);
               failures++;
            end
         end
         if ($urandom_range(0, 15) == 0) sink_idles = !sink_idles;
         nxt = sink_idles ? $urandom_range(0, 6) : 0;
      end else if (nxt > 0) begin
         nxt--;
      end
      stall_left    <= nxt;
      rsp_bus.ready <= (nxt == 0);
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles >= TimeoutCycles) begin
         $display("tb_top: FAIL");
         $finish;
      end
   end

endmodule
